FILE: rtl/core/lasb_pkg.sv
package lasb_pkg;

  localparam int CW      = 24;  // coordinate width
  localparam int DW      = 25;  // difference vector width
  localparam int XW      = 48;  // vectoring datapath width
  localparam int SQW     = 50;  // squared length width
  localparam int RW      = 25;  // rounded length width
  localparam int PW      = 32;  // phase width, 2^-32 turns
  localparam int ITERS   = 30;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic signed [31:0] COORD_MAX = 32'sd8388607;
  localparam logic signed [31:0] COORD_MIN = -32'sd8388608;
  localparam logic signed [63:0] K_INV_Q30 = 64'sd652032874;
  localparam logic [PW-1:0]      HALF_TURN = 32'h80000000;

  localparam logic [31:0] TURN_ATAN [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] cursor_x;
    logic signed [CW-1:0] cursor_y;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] snapped_x;
    logic signed [CW-1:0] snapped_y;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic [RW-1:0]        len;
    logic [PW-1:0]        ph;
  } item_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [PW-1:0]        z;
  } vec_t;

  typedef struct packed {
    logic [SQW-1:0] op;
    logic [SQW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [31:0] v);
    if (v > COORD_MAX) return COORD_MAX[CW-1:0];
    else if (v < COORD_MIN) return COORD_MIN[CW-1:0];
    else return v[CW-1:0];
  endfunction

  // one vectoring iteration: drive y toward zero
  function automatic vec_t vstep(input vec_t v, input int i);
    vec_t o;
    o = v;
    if (v.y > 0) begin
      o.x = v.x + (v.y >>> i);
      o.y = v.y - (v.x >>> i);
      o.z = v.z + TURN_ATAN[i];
    end else begin
      o.x = v.x - (v.y >>> i);
      o.y = v.y + (v.x >>> i);
      o.z = v.z - TURN_ATAN[i];
    end
    return o;
  endfunction

  // one digit of the restoring square root
  function automatic sq_t sqstep(input sq_t r, input int b);
    sq_t o;
    logic [SQW-1:0] one;
    logic [SQW-1:0] t;
    one = SQW'(1) << (2 * b);
    t   = r.res + one;
    if (r.op >= t) begin
      o.op  = r.op - t;
      o.res = (r.res >> 1) + one;
    end else begin
      o.op  = r.op;
      o.res = r.res >> 1;
    end
    return o;
  endfunction

  // rotation of 1/K by a phase; evaluated for the constant direction table
  function automatic cs_t cos_sin(input logic [31:0] p);
    logic [1:0] q;
    logic [31:0] ru;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    cs_t r;
    q  = 2'((p + 32'h20000000) >> 30);
    ru = p - {q, 30'b0};
    z  = 64'($signed(ru));
    x  = K_INV_Q30;
    y  = '0;
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - $signed({32'b0, TURN_ATAN[i]});
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + $signed({32'b0, TURN_ATAN[i]});
      end
    end
    case (q)
      2'd0: begin r.c = 32'(x);  r.s = 32'(y);  end
      2'd1: begin r.c = 32'(-y); r.s = 32'(x);  end
      2'd2: begin r.c = 32'(-x); r.s = 32'(-y); end
      default: begin r.c = 32'(y); r.s = 32'(-x); end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/lasb_front.sv
module lasb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  lasb_pkg::in_t    in_data,
  output logic             item_valid,
  output lasb_pkg::item_t  item
);

  localparam int NS = 32;

  logic                              vld [NS];
  logic signed [lasb_pkg::CW-1:0]    sx_p [NS];
  logic signed [lasb_pkg::CW-1:0]    sy_p [NS];
  logic signed [lasb_pkg::DW-1:0]    dx0;
  logic signed [lasb_pkg::DW-1:0]    dy0;
  logic signed [lasb_pkg::SQW-1:0]   sqa;
  logic signed [lasb_pkg::SQW-1:0]   sqb;
  lasb_pkg::vec_t                    v [1:NS-1];
  lasb_pkg::sq_t                     r [2:27];
  logic [lasb_pkg::RW-1:0]           len_p [28:NS-1];
  lasb_pkg::vec_t                    v_init;
  logic signed [lasb_pkg::XW-1:0]    ex0;
  logic signed [lasb_pkg::XW-1:0]    ey0;

  // fold the left half plane onto the right one
  always_comb begin
    ex0 = lasb_pkg::XW'(dx0);
    ey0 = lasb_pkg::XW'(dy0);
    if (dx0 < 0) begin
      v_init.x = (-ex0) <<< 20;
      v_init.y = (-ey0) <<< 20;
      v_init.z = lasb_pkg::HALF_TURN;
    end else begin
      v_init.x = ex0 <<< 20;
      v_init.y = ey0 <<< 20;
      v_init.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NS; e++) vld[e] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int e = 1; e < NS; e++) vld[e] <= vld[e-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_p[0] <= in_data.start_x;
      sy_p[0] <= in_data.start_y;
      dx0 <= lasb_pkg::DW'(in_data.cursor_x) - lasb_pkg::DW'(in_data.start_x);
      dy0 <= lasb_pkg::DW'(in_data.cursor_y) - lasb_pkg::DW'(in_data.start_y);
      for (int e = 1; e < NS; e++) begin
        sx_p[e] <= sx_p[e-1];
        sy_p[e] <= sy_p[e-1];
      end
      v[1] <= v_init;
      sqa  <= dx0 * dx0;
      sqb  <= dy0 * dy0;
      for (int e = 2; e < NS; e++) v[e] <= lasb_pkg::vstep(v[e-1], e - 2);
      r[2].op  <= $unsigned(sqa) + $unsigned(sqb);
      r[2].res <= '0;
      for (int e = 3; e < 28; e++) r[e] <= lasb_pkg::sqstep(r[e-1], 27 - e);
      // round the root: a remainder above the root means the half rounds up
      len_p[28] <= lasb_pkg::RW'(r[27].res) +
                   lasb_pkg::RW'(r[27].op > r[27].res);
      for (int e = 29; e < NS; e++) len_p[e] <= len_p[e-1];
    end
  end

  assign item_valid = vld[NS-1];
  assign item.sx  = sx_p[NS-1];
  assign item.sy  = sy_p[NS-1];
  assign item.len = len_p[NS-1];
  assign item.ph  = v[NS-1].z;

endmodule

FILE: rtl/core/lasb_fifo.sv
module lasb_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lasb_pkg::item_t   push_item,
  input  logic              pop,
  output lasb_pkg::item_t   head_item,
  output lasb_pkg::qstat_t  stat
);

  lasb_pkg::item_t              mem [lasb_pkg::QDEPTH];
  logic [lasb_pkg::QAW-1:0]     wp;
  logic [lasb_pkg::QAW-1:0]     rp;
  logic [lasb_pkg::QAW:0]       cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_item;
  end

  assign head_item  = mem[rp];
  assign stat.full  = (cnt == (lasb_pkg::QAW + 1)'(lasb_pkg::QDEPTH));
  assign stat.avail = (cnt != '0);

endmodule

FILE: rtl/core/lasb_back.sv
module lasb_back #(
  parameter int DIRECTIONS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       stroke_width,
  input  logic             in_avail,
  input  lasb_pkg::item_t  in_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output lasb_pkg::out_t   out_data
);

  localparam int KW  = $clog2(DIRECTIONS + 1);
  localparam int IW  = $clog2(DIRECTIONS);
  localparam int PRW = lasb_pkg::PW + KW;
  localparam int MW  = lasb_pkg::RW + 1 + 32;
  localparam int OW  = 28;
  localparam int CW  = lasb_pkg::CW;

  lasb_pkg::cs_t tab [DIRECTIONS];

  for (genvar gk = 0; gk < DIRECTIONS; gk++) begin : g_dir
    localparam logic [31:0] TG = 32'((64'(gk) << 32) / DIRECTIONS);
    localparam lasb_pkg::cs_t CS = lasb_pkg::cos_sin(TG);
    assign tab[gk] = CS;
  end

  logic                  en;
  logic                  va, vb, vc, vd, ve;
  logic [PRW-1:0]        prod;
  logic [KW-1:0]         kraw;
  logic [IW-1:0]         kidx;

  logic signed [CW-1:0]  sxa, sya, sxb, syb, sxc, syc, sxd, syd;
  logic [lasb_pkg::RW-1:0] lena;
  lasb_pkg::cs_t         csa;
  logic signed [MW-1:0]  mxb, myb;
  logic signed [OW-1:0]  offxc, offyc;
  logic signed [CW-1:0]  exd, eyd;
  logic signed [31:0]    w32;

  function automatic logic signed [OW-1:0] rnd(input logic signed [MW-1:0] m);
    logic [MW-1:0] a;
    logic [MW-1:0] t;
    a = (m < 0) ? $unsigned(-m) : $unsigned(m);
    t = (a + (MW'(1) << 29)) >> 30;
    return (m < 0) ? -$signed(OW'(t)) : $signed(OW'(t));
  endfunction

  // nearest direction, half step up, last index wraps to zero
  always_comb begin
    prod = PRW'(in_item.ph) * PRW'(DIRECTIONS) + PRW'(lasb_pkg::HALF_TURN);
    kraw = prod[PRW-1:lasb_pkg::PW];
    kidx = (kraw >= KW'(DIRECTIONS)) ? '0 : kraw[IW-1:0];
  end

  assign en  = !ve || out_ready;
  assign pop = en && in_avail;
  assign w32 = {16'b0, stroke_width, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      va <= in_avail;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxa  <= in_item.sx;
      sya  <= in_item.sy;
      lena <= in_item.len;
      csa  <= tab[kidx];

      sxb <= sxa;
      syb <= sya;
      mxb <= $signed({1'b0, lena}) * csa.c;
      myb <= $signed({1'b0, lena}) * csa.s;

      sxc   <= sxb;
      syc   <= syb;
      offxc <= rnd(mxb);
      offyc <= rnd(myb);

      sxd <= sxc;
      syd <= syc;
      exd <= lasb_pkg::sat(32'(sxc) + 32'(offxc));
      eyd <= lasb_pkg::sat(32'(syc) + 32'(offyc));

      out_data.snapped_x <= exd;
      out_data.snapped_y <= eyd;
      out_data.box_min_x <= lasb_pkg::sat(32'((sxd < exd) ? sxd : exd) - w32);
      out_data.box_min_y <= lasb_pkg::sat(32'((syd < eyd) ? syd : eyd) - w32);
      out_data.box_max_x <= lasb_pkg::sat(32'((sxd < exd) ? exd : sxd) + w32);
      out_data.box_max_y <= lasb_pkg::sat(32'((syd < eyd) ? eyd : syd) + w32);
    end
  end

  assign out_valid = ve;

endmodule

FILE: rtl/core/line_angle_snap_with_bounds.sv
// Snaps the line from start to cursor onto the nearest of DIRECTIONS evenly
// spaced directions, keeps its length, and returns the snapped end point and
// the stroke-widened bounding box. One request is taken every clock cycle
// while the queue has room. The front end (a 30-stage vectoring CORDIC for
// the angle beside a 25-stage square-root pipeline for the length)
// advances one stage per cycle and stalls only when its 4-entry queue is
// full; the back end (direction table, one 26x32 multiply per axis,
// rounding, saturation and box) is five stages and stalls only on the
// output handshake.
module line_angle_snap_with_bounds #(
  parameter int DIRECTIONS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lasb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lasb_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data
);

  logic [7:0]        stroke_width;
  logic              front_en;
  logic              item_valid;
  lasb_pkg::item_t   item;
  lasb_pkg::item_t   head_item;
  lasb_pkg::qstat_t  qstat;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) stroke_width <= 8'd1;
    else if (cfg_we) stroke_width <= cfg_data;
  end

  // hold the whole front pipeline while the queue has no room
  assign front_en = !qstat.full;
  assign in_ready = front_en;

  lasb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (front_en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item)
  );

  lasb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_en && item_valid),
    .push_item (item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  lasb_back #(
    .DIRECTIONS (DIRECTIONS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .stroke_width (stroke_width),
    .in_avail     (qstat.avail),
    .in_item      (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
